// ===== src/dfst_pkg.sv =====
// Shared types and constants of the deauth frame source tracker.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package dfst_pkg;

	localparam logic [1:0] OP_FRAME = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [3:0] ST_FILTERED     = 4'd0;
	localparam logic [3:0] ST_HIT          = 4'd1;
	localparam logic [3:0] ST_NEW          = 4'd2;
	localparam logic [3:0] ST_FULL_DROPPED = 4'd3;
	localparam logic [3:0] ST_TICK_IDLE    = 4'd4;
	localparam logic [3:0] ST_REPORT       = 4'd5;
	localparam logic [3:0] ST_REPORT_ALERT = 4'd6;
	localparam logic [3:0] ST_READ_OK      = 4'd7;
	localparam logic [3:0] ST_READ_INVALID = 4'd8;

	localparam logic [0:0] CFG_UPDATE_INTERVAL = 1'd0;
	localparam logic [0:0] CFG_ALERT_THRESHOLD = 1'd1;
	localparam int         CFG_IDX_W           = 1;
	localparam int         CFG_DATA_W          = 16;
	localparam logic [15:0] INTERVAL_RESET     = 16'd1000;
	localparam logic [15:0] THRESHOLD_RESET    = 16'd10;

	localparam logic [11:0] MIN_FRAME_LEN = 12'd26;
	localparam logic [7:0]  FC_DEAUTH     = 8'hC0;
	localparam logic [7:0]  FC_DISASSOC   = 8'hA0;
	localparam logic [9:0]  MS_PER_SEC    = 10'd1000;
	localparam logic [15:0] FPS_MAX       = 16'hFFFF;

	// interval count times 1000 fits in 42 bits
	localparam int NUM_W = 42;
	localparam int DIV_CNT_W = 6;

	typedef struct packed {
		logic [47:0] src;
		logic [47:0] net;
		logic [31:0] hits;
		logic [31:0] first;
		logic [31:0] last;
		logic [3:0]  chan;
		logic [7:0]  sig;
		logic        disassoc;
		logic [7:0]  reason;
	} entry_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [8:0]  slot;
		logic [31:0] count;
		entry_t      entry;
		logic [15:0] fps;
	} result_t;

	typedef enum logic [2:0] {
		RK_FILTERED,
		RK_HIT,
		RK_NEW,
		RK_FULL,
		RK_TICK,
		RK_RATE,
		RK_READ,
		RK_INVALID
	} res_kind_t;

	typedef struct packed {
		logic      load_in;
		logic      count_frame;
		logic      scan_start;
		logic      scan_step;
		logic      write_hit;
		logic      write_new;
		logic      start_rate;
		logic      div_step;
		logic      fetch;
		logic      load_res;
		res_kind_t kind;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       frame_pass;
		logic       tick_due;
		logic       read_ok;
		logic       scan_hit;
		logic       scan_done;
		logic       table_full;
		logic       div_done;
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== src/dfst_datapath.sv =====
// Datapath of the tracker: request latch, entry table, counters, rate divider.
// Depends on dfst_pkg; driven by dfst_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module dfst_datapath #(
	parameter int ENTRIES = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [dfst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dfst_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic [1:0]                    operation,
	input  wire logic                          is_management,
	input  wire logic [11:0]                   frame_length,
	input  wire logic [7:0]                    frame_control,
	input  wire logic [47:0]                   source_address,
	input  wire logic [47:0]                   network_id,
	input  wire logic [7:0]                    reason_in,
	input  wire logic signed [7:0]             signal_level,
	input  wire logic [3:0]                    radio_channel,
	input  wire logic [31:0]                   now_ms,
	input  wire logic [7:0]                    read_index,
	input  wire dfst_pkg::dp_cmd_t             cmd,
	output dfst_pkg::dp_sts_t                  sts,
	output dfst_pkg::result_t                  res
);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int NW = dfst_pkg::NUM_W;

	// latched request
	logic [1:0]  op_q;
	logic        mgmt_q;
	logic [11:0] len_q;
	logic [7:0]  fc_q;
	logic [47:0] src_q;
	logic [47:0] net_q;
	logic [7:0]  reason_q;
	logic [7:0]  sig_q;
	logic [3:0]  chan_q;
	logic [31:0] now_q;
	logic [7:0]  ridx_q;

	logic [15:0] intv_q;
	logic [15:0] thr_q;
	logic [CW-1:0] used_q;
	logic [31:0] total_q;
	logic [31:0] icount_q;
	logic [31:0] last_rep_q;

	dfst_pkg::entry_t mem_q [ENTRIES];
	dfst_pkg::entry_t rd_q;
	dfst_pkg::entry_t wr_data;
	dfst_pkg::entry_t upd_entry;
	dfst_pkg::entry_t new_entry;
	logic [IW-1:0] wr_addr;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic          rd_en;

	logic [CW-1:0] scan_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic          scan_issue;
	logic          scan_hit;

	logic [NW-1:0] num_q;
	logic [NW-1:0] quo_q;
	logic [31:0]   rem_q;
	logic [31:0]   den_q;
	logic [dfst_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [32:0]   rem_sh;
	logic          rem_ge;

	logic [31:0] elapsed;
	logic        fps_sat;
	logic        den_zero;
	logic [15:0] fps;
	logic        alert;
	dfst_pkg::result_t res_d;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q     <= operation;
			mgmt_q   <= is_management;
			len_q    <= frame_length;
			fc_q     <= frame_control;
			src_q    <= source_address;
			net_q    <= network_id;
			reason_q <= reason_in;
			sig_q    <= signal_level;
			chan_q   <= radio_channel;
			now_q    <= now_ms;
			ridx_q   <= read_index;
		end
	end

	assign elapsed = now_q - last_rep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intv_q     <= dfst_pkg::INTERVAL_RESET;
			thr_q      <= dfst_pkg::THRESHOLD_RESET;
			used_q     <= '0;
			total_q    <= '0;
			icount_q   <= '0;
			last_rep_q <= '0;
		end else begin
			if (cfg_wr_en && cfg_index == dfst_pkg::CFG_UPDATE_INTERVAL) begin
				intv_q <= cfg_wdata;
			end
			if (cfg_wr_en && cfg_index == dfst_pkg::CFG_ALERT_THRESHOLD) begin
				thr_q <= cfg_wdata;
			end
			if (cmd.count_frame) begin
				total_q  <= total_q + 32'd1;
				icount_q <= icount_q + 32'd1;
			end
			if (cmd.write_new) begin
				used_q <= used_q + CW'(1);
			end
			if (cmd.start_rate) begin
				icount_q   <= '0;
				last_rep_q <= now_q;
			end
		end
	end

	// linear search: one read issued per cycle, compared in the cycle after it is issued
	assign scan_hit   = vld_s1 && rd_q.src == src_q && rd_q.net == net_q;
	assign scan_issue = cmd.scan_step && !scan_hit && scan_q < used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			vld_s1 <= 1'b0;
		end else if (cmd.scan_start) begin
			scan_q <= '0;
			vld_s1 <= 1'b0;
		end else if (cmd.scan_step && !scan_hit) begin
			vld_s1 <= scan_issue;
			if (scan_issue) begin
				scan_q <= scan_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_issue) begin
			idx_s1 <= scan_q[IW-1:0];
		end
	end

	always_comb begin
		upd_entry      = rd_q;
		upd_entry.hits = rd_q.hits + 32'd1;
		upd_entry.last = now_q;
		upd_entry.sig  = sig_q;
		new_entry.src      = src_q;
		new_entry.net      = net_q;
		new_entry.hits     = 32'd1;
		new_entry.first    = now_q;
		new_entry.last     = now_q;
		new_entry.chan     = chan_q;
		new_entry.sig      = sig_q;
		new_entry.disassoc = (fc_q == dfst_pkg::FC_DISASSOC);
		new_entry.reason   = reason_q;
	end

	assign wr_en   = cmd.write_hit || cmd.write_new;
	assign wr_addr = cmd.write_hit ? idx_s1 : used_q[IW-1:0];
	assign wr_data = cmd.write_hit ? upd_entry : new_entry;
	assign rd_en   = scan_issue || cmd.fetch;
	assign rd_addr = cmd.fetch ? ridx_q[IW-1:0] : scan_q[IW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// restoring division, one quotient bit per cycle
	assign rem_sh = {rem_q, num_q[NW-1]};
	assign rem_ge = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start_rate) begin
			cnt_q <= dfst_pkg::DIV_CNT_W'(NW);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - dfst_pkg::DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_rate) begin
			num_q <= NW'(icount_q) * NW'(dfst_pkg::MS_PER_SEC);
			den_q <= elapsed;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sh[31:0] - den_q : rem_sh[31:0];
			quo_q <= {quo_q[NW-2:0], rem_ge};
			num_q <= {num_q[NW-2:0], 1'b0};
		end
	end

	assign den_zero = (den_q == '0);
	assign fps_sat  = |quo_q[NW-1:16];
	assign fps      = den_zero ? '0 : (fps_sat ? dfst_pkg::FPS_MAX : quo_q[15:0]);
	assign alert    = !den_zero && (fps_sat || quo_q[15:0] > thr_q);

	always_comb begin
		res_d = '0;
		unique case (cmd.kind)
			dfst_pkg::RK_FILTERED: res_d.status = dfst_pkg::ST_FILTERED;
			dfst_pkg::RK_HIT: begin
				res_d.status = dfst_pkg::ST_HIT;
				res_d.slot   = 9'(idx_s1);
				res_d.count  = upd_entry.hits;
				res_d.entry  = upd_entry;
			end
			dfst_pkg::RK_NEW: begin
				res_d.status = dfst_pkg::ST_NEW;
				res_d.slot   = 9'(used_q);
				res_d.count  = new_entry.hits;
				res_d.entry  = new_entry;
			end
			dfst_pkg::RK_FULL: begin
				res_d.status = dfst_pkg::ST_FULL_DROPPED;
				res_d.slot   = 9'(used_q);
			end
			dfst_pkg::RK_TICK: begin
				res_d.status = dfst_pkg::ST_TICK_IDLE;
				res_d.slot   = 9'(used_q);
				res_d.count  = total_q;
			end
			dfst_pkg::RK_RATE: begin
				res_d.status = alert ? dfst_pkg::ST_REPORT_ALERT : dfst_pkg::ST_REPORT;
				res_d.slot   = 9'(used_q);
				res_d.count  = total_q;
				res_d.fps    = fps;
			end
			dfst_pkg::RK_READ: begin
				res_d.status = dfst_pkg::ST_READ_OK;
				res_d.slot   = 9'(ridx_q);
				res_d.count  = rd_q.hits;
				res_d.entry  = rd_q;
			end
			dfst_pkg::RK_INVALID: res_d.status = dfst_pkg::ST_READ_INVALID;
			default: res_d.status = dfst_pkg::ST_READ_INVALID;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			res <= res_d;
		end
	end

	always_comb begin
		sts.op         = op_q;
		sts.frame_pass = mgmt_q && len_q >= dfst_pkg::MIN_FRAME_LEN &&
			(fc_q == dfst_pkg::FC_DEAUTH || fc_q == dfst_pkg::FC_DISASSOC);
		sts.tick_due   = elapsed >= 32'(intv_q);
		sts.read_ok    = 9'(ridx_q) < 9'(used_q);
		sts.scan_hit   = scan_hit;
		sts.scan_done  = !vld_s1 && scan_q == used_q;
		sts.table_full = used_q == CW'(ENTRIES);
		sts.div_done   = cnt_q == '0;
	end

endmodule
`default_nettype wire

// ===== src/dfst_ctrl.sv =====
// Controller state machine of the tracker: handshakes and sequencing.
// Depends on dfst_pkg; drives dfst_datapath.
`timescale 1ns / 1ps
`default_nettype none
module dfst_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire dfst_pkg::dp_sts_t sts,
	output dfst_pkg::dp_cmd_t      cmd
);
	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_DISP  = 11'b000_0000_0010,
		S_SCAN  = 11'b000_0000_0100,
		S_HIT   = 11'b000_0000_1000,
		S_MISS  = 11'b000_0001_0000,
		S_MUL   = 11'b000_0010_0000,
		S_DIV   = 11'b000_0100_0000,
		S_RATE  = 11'b000_1000_0000,
		S_FETCH = 11'b001_0000_0000,
		S_READ  = 11'b010_0000_0000,
		S_OUT   = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.kind = dfst_pkg::RK_INVALID;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				unique case (sts.op)
					dfst_pkg::OP_FRAME: begin
						if (sts.frame_pass) begin
							cmd.count_frame = 1'b1;
							cmd.scan_start  = 1'b1;
							state_d         = S_SCAN;
						end else begin
							cmd.load_res = 1'b1;
							cmd.kind     = dfst_pkg::RK_FILTERED;
							state_d      = S_OUT;
						end
					end
					dfst_pkg::OP_TICK: begin
						if (sts.tick_due) begin
							state_d = S_MUL;
						end else begin
							cmd.load_res = 1'b1;
							cmd.kind     = dfst_pkg::RK_TICK;
							state_d      = S_OUT;
						end
					end
					dfst_pkg::OP_READ: begin
						if (sts.read_ok) begin
							state_d = S_FETCH;
						end else begin
							cmd.load_res = 1'b1;
							state_d      = S_OUT;
						end
					end
					default: begin
						cmd.load_res = 1'b1;
						state_d      = S_OUT;
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				priority if (sts.scan_hit) begin
					state_d = S_HIT;
				end else if (sts.scan_done) begin
					state_d = S_MISS;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_HIT: begin
				cmd.write_hit = 1'b1;
				cmd.load_res  = 1'b1;
				cmd.kind      = dfst_pkg::RK_HIT;
				state_d       = S_OUT;
			end
			S_MISS: begin
				cmd.load_res = 1'b1;
				if (sts.table_full) begin
					cmd.kind = dfst_pkg::RK_FULL;
				end else begin
					cmd.write_new = 1'b1;
					cmd.kind      = dfst_pkg::RK_NEW;
				end
				state_d = S_OUT;
			end
			S_MUL: begin
				cmd.start_rate = 1'b1;
				state_d        = S_DIV;
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_d = S_RATE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_RATE: begin
				cmd.load_res = 1'b1;
				cmd.kind     = dfst_pkg::RK_RATE;
				state_d      = S_OUT;
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = S_READ;
			end
			S_READ: begin
				cmd.load_res = 1'b1;
				cmd.kind     = dfst_pkg::RK_READ;
				state_d      = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ===== src/deauth_frame_source_tracker_core.sv =====
// Top level of the deauth frame source tracker.
// Depends on dfst_pkg, dfst_ctrl and dfst_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Takes one request at a time and returns one result per request. For a frame
// that fails the filter, an idle tick or an invalid read, the result is loaded in
// the dispatch state right after the request is latched; a read of a stored entry
// first passes through the fetch and read states. A passing frame walks the entry
// table through a single registered memory read port, one entry a cycle. A tick
// that closes an interval runs a one-bit-per-cycle restoring divider over the
// 42-bit product. The next request is taken in the cycle after the result is.
// Table contents are undefined after reset; only entries below the fill count
// are ever read, so no clearing pass is needed.
module deauth_frame_source_tracker_core #(
	parameter int ENTRIES = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [dfst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dfst_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [1:0]                      operation,
	input  wire logic                            is_management,
	input  wire logic [11:0]                     frame_length,
	input  wire logic [7:0]                      frame_control,
	input  wire logic [47:0]                     source_address,
	input  wire logic [47:0]                     network_id,
	input  wire logic [7:0]                      reason_in,
	input  wire logic signed [7:0]               signal_level,
	input  wire logic [3:0]                      radio_channel,
	input  wire logic [31:0]                     now_ms,
	input  wire logic [7:0]                      read_index,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [3:0]                           status,
	output logic [8:0]                           slot,
	output logic [31:0]                          count_value,
	output logic [47:0]                          source_out,
	output logic [47:0]                          network_out,
	output logic [3:0]                           channel_out,
	output logic signed [7:0]                    signal_out,
	output logic [31:0]                          first_seen_out,
	output logic [31:0]                          last_seen_out,
	output logic                                 is_disassoc,
	output logic [7:0]                           reason_out,
	output logic [15:0]                          frames_per_second
);
	dfst_pkg::dp_cmd_t cmd;
	dfst_pkg::dp_sts_t sts;
	dfst_pkg::result_t res;

	dfst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	dfst_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.operation      (operation),
		.is_management  (is_management),
		.frame_length   (frame_length),
		.frame_control  (frame_control),
		.source_address (source_address),
		.network_id     (network_id),
		.reason_in      (reason_in),
		.signal_level   (signal_level),
		.radio_channel  (radio_channel),
		.now_ms         (now_ms),
		.read_index     (read_index),
		.cmd            (cmd),
		.sts            (sts),
		.res            (res)
	);

	assign status            = res.status;
	assign slot              = res.slot;
	assign count_value       = res.count;
	assign source_out        = res.entry.src;
	assign network_out       = res.entry.net;
	assign channel_out       = res.entry.chan;
	assign signal_out        = $signed(res.entry.sig);
	assign first_seen_out    = res.entry.first;
	assign last_seen_out     = res.entry.last;
	assign is_disassoc       = res.entry.disassoc;
	assign reason_out        = res.entry.reason;
	assign frames_per_second = res.fps;

	// one request in flight: once taken, no other until its result leaves
	a_single_request: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted while another is in flight");

	a_busy_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (slot <= 9'(ENTRIES)))
		else $error("slot beyond table size");

	a_fps_only_report: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != dfst_pkg::ST_REPORT && status != dfst_pkg::ST_REPORT_ALERT)
		|-> (frames_per_second == '0))
		else $error("rate on a non-report result");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for deauth_frame_source_tracker_core: random and directed requests,
// a behavioral predictor of the source table and rate reports, in-order compare.
// Depends on dfst_pkg and the core RTL.
`timescale 1ns / 1ps
`default_nettype none

class tracker_scoreboard;
	// predictor state
	logic [47:0] tab_src[32];
	logic [47:0] tab_net[32];
	logic [31:0] tab_hits[32];
	logic [31:0] tab_first[32];
	logic [31:0] tab_last[32];
	logic [3:0]  tab_chan[32];
	logic [7:0]  tab_sig[32];
	logic        tab_dis[32];
	logic [7:0]  tab_reason[32];
	int unsigned used;
	logic [31:0] total, intv, last_rep;
	logic [15:0] interval_ms, threshold;
	dfst_pkg::result_t pending[$];
	int errors;

	function new();
		used = 0; total = 0; intv = 0; last_rep = 0;
		interval_ms = dfst_pkg::INTERVAL_RESET;
		threshold = dfst_pkg::THRESHOLD_RESET;
		errors = 0;
	endfunction

	function void set_reg(logic [0:0] idx, logic [15:0] val);
		if (idx == dfst_pkg::CFG_UPDATE_INTERVAL) interval_ms = val;
		else threshold = val;
	endfunction

	function void fill_entry(ref dfst_pkg::result_t r, input int i);
		r.count = tab_hits[i];
		r.entry.src = tab_src[i]; r.entry.net = tab_net[i];
		r.entry.hits = tab_hits[i]; r.entry.chan = tab_chan[i];
		r.entry.sig = tab_sig[i]; r.entry.first = tab_first[i];
		r.entry.last = tab_last[i]; r.entry.disassoc = tab_dis[i];
		r.entry.reason = tab_reason[i];
	endfunction

	function void note_request(logic [1:0] op, logic mgmt, logic [11:0] flen,
			logic [7:0] fc, logic [47:0] src, logic [47:0] net, logic [7:0] rsn,
			logic [7:0] sig, logic [3:0] chan, logic [31:0] now, logic [7:0] ridx);
		dfst_pkg::result_t r;
		logic [31:0] elapsed;
		logic [63:0] fps;
		int hit;
		r = '0;
		hit = -1;
		if (op == dfst_pkg::OP_FRAME) begin
			if (!mgmt || flen < dfst_pkg::MIN_FRAME_LEN ||
					(fc != dfst_pkg::FC_DEAUTH && fc != dfst_pkg::FC_DISASSOC)) begin
				r.status = dfst_pkg::ST_FILTERED;
			end else begin
				total++; intv++;
				for (int i = 0; i < used; i++)
					if (hit < 0 && tab_src[i] == src && tab_net[i] == net) hit = i;
				if (hit >= 0) begin
					tab_hits[hit]++; tab_last[hit] = now; tab_sig[hit] = sig;
					r.status = dfst_pkg::ST_HIT; r.slot = 9'(hit);
					fill_entry(r, hit);
				end else if (used < 32) begin
					tab_src[used] = src; tab_net[used] = net; tab_hits[used] = 1;
					tab_first[used] = now; tab_last[used] = now; tab_chan[used] = chan;
					tab_sig[used] = sig; tab_dis[used] = (fc == dfst_pkg::FC_DISASSOC);
					tab_reason[used] = rsn;
					r.status = dfst_pkg::ST_NEW; r.slot = 9'(used);
					fill_entry(r, used);
					used++;
				end else begin
					r.status = dfst_pkg::ST_FULL_DROPPED; r.slot = 9'(used);
				end
			end
		end else if (op == dfst_pkg::OP_TICK) begin
			elapsed = now - last_rep;
			r.slot = 9'(used); r.count = total;
			if (elapsed >= interval_ms) begin
				fps = (elapsed == 0) ? 64'd0 : ({32'd0, intv} * 64'd1000) / elapsed;
				intv = 0; last_rep = now;
				r.status = (fps > threshold) ? dfst_pkg::ST_REPORT_ALERT
					: dfst_pkg::ST_REPORT;
				r.fps = (fps > 64'hFFFF) ? dfst_pkg::FPS_MAX : fps[15:0];
			end else begin
				r.status = dfst_pkg::ST_TICK_IDLE;
			end
		end else if (op == dfst_pkg::OP_READ && ridx < used) begin
			r.status = dfst_pkg::ST_READ_OK; r.slot = 9'(ridx);
			fill_entry(r, ridx);
		end else begin
			r.status = dfst_pkg::ST_READ_INVALID;
		end
		pending = {pending, r};
	endfunction

	function void check_result(dfst_pkg::result_t got);
		dfst_pkg::result_t want;
		// hits field is not a port; compare everything else
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected result status=%0d", got.status);
			return;
		end
		want = pending.pop_front();
		got.entry.hits = want.entry.hits;
		if (got !== want) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: expected %h actual %h", want, got);
		end
	endfunction
endclass

module tb;
	logic clk = 0, arst_n = 0;
	logic cfg_wr_en = 0;
	logic [0:0] cfg_index = '0;
	logic [15:0] cfg_wdata = '0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic [1:0] operation = '0;
	logic is_management = 0;
	logic [11:0] frame_length = '0;
	logic [7:0] frame_control = '0;
	logic [47:0] source_address = '0, network_id = '0;
	logic [7:0] reason_in = '0;
	logic signed [7:0] signal_level = '0;
	logic [3:0] radio_channel = '0;
	logic [31:0] now_ms = '0;
	logic [7:0] read_index = '0;
	logic [3:0] status;
	logic [8:0] slot;
	logic [31:0] count_value, first_seen_out, last_seen_out;
	logic [47:0] source_out, network_out;
	logic [3:0] channel_out;
	logic signed [7:0] signal_out;
	logic is_disassoc;
	logic [7:0] reason_out;
	logic [15:0] frames_per_second;

	tracker_scoreboard sb = new();
	int unsigned cycles = 0;
	logic [31:0] clock_ms = 0;
	logic [47:0] known_src[8], known_net[8];
	bit done = 0;

	deauth_frame_source_tracker_core dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// receiver: random stall, check on accept
	always @(posedge clk) begin
		dfst_pkg::result_t r;
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			r = '0;
			r.status = status; r.slot = slot; r.count = count_value;
			r.entry.src = source_out; r.entry.net = network_out;
			r.entry.chan = channel_out; r.entry.sig = signal_out;
			r.entry.first = first_seen_out; r.entry.last = last_seen_out;
			r.entry.disassoc = is_disassoc; r.entry.reason = reason_out;
			r.fps = frames_per_second;
			sb.check_result(r);
		end
		if (done) out_stall <= 0;
		else out_stall <= ($urandom_range(0, 99) < 25) ? ($urandom_range(0, 9) == 0) |
			($urandom_range(0, 3) != 0) : 1'b0;
	end

	always @(posedge clk) if (cycles > 2000000) begin
		$display("TB_ERROR");
		$finish;
	end

	// valid stays up after an accept only when the next request follows at once
	task automatic send_request(logic [1:0] op, logic mgmt, logic [11:0] flen,
			logic [7:0] fc, logic [47:0] src, logic [47:0] net, logic [7:0] rsn,
			logic [7:0] sig, logic [3:0] chan, logic [31:0] now, logic [7:0] ridx);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		operation <= op; is_management <= mgmt; frame_length <= flen;
		frame_control <= fc; source_address <= src; network_id <= net;
		reason_in <= rsn; signal_level <= sig; radio_channel <= chan;
		now_ms <= now; read_index <= ridx; in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(op, mgmt, flen, fc, src, net, rsn, sig, chan, now, ridx);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [15:0] val);
		cfg_index <= idx; cfg_wdata <= val; cfg_wr_en <= 1;
		@(posedge clk);
		cfg_wr_en <= 0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic frame(logic [47:0] src, logic [47:0] net, logic [7:0] fc);
		send_request(dfst_pkg::OP_FRAME, 1, 12'($urandom_range(26, 4095)), fc, src, net,
			8'($urandom), 8'($urandom), 4'($urandom), clock_ms, 8'($urandom));
	endtask

	task automatic random_request();
		int p, k;
		logic [47:0] s, n;
		clock_ms += $urandom_range(0, 400);
		if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
		p = $urandom_range(0, 99);
		k = $urandom_range(0, 7);
		s = ($urandom_range(0, 3) == 0) ? 48'({$urandom, $urandom}) : known_src[k];
		n = ($urandom_range(0, 3) == 0) ? 48'({$urandom, $urandom}) : known_net[k];
		if (p < 55)
			frame(s, n, ($urandom_range(0, 1) ? dfst_pkg::FC_DEAUTH : dfst_pkg::FC_DISASSOC));
		else if (p < 65)
			send_request(dfst_pkg::OP_FRAME, 1'($urandom), 12'($urandom), 8'($urandom),
				48'({$urandom, $urandom}), 48'({$urandom, $urandom}), 8'($urandom),
				8'($urandom), 4'($urandom), $urandom, 8'($urandom));
		else if (p < 82)
			send_request(dfst_pkg::OP_TICK, 1'($urandom), 12'($urandom), 8'($urandom),
				48'({$urandom, $urandom}), 48'({$urandom, $urandom}), 8'($urandom),
				8'($urandom), 4'($urandom), clock_ms, 8'($urandom));
		else
			send_request(2'($urandom_range(2, 3)), 1'($urandom), 12'($urandom),
				8'($urandom), 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
				8'($urandom), 8'($urandom), 4'($urandom), $urandom,
				8'($urandom_range(0, 40) | ($urandom_range(0, 19) == 0 ? 8'h80 : 8'h00)));
	endtask

	initial begin
		for (int i = 0; i < 8; i++) begin
			known_src[i] = 48'({$urandom, $urandom});
			known_net[i] = 48'({$urandom, $urandom});
		end
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: filter edges, extremes, reads, ticks
		send_request(dfst_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_request(dfst_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 5, 0);
		send_request(dfst_pkg::OP_FRAME, 0, 100, dfst_pkg::FC_DEAUTH, 1, 2, 3, 4, 5, 6, 0);
		send_request(dfst_pkg::OP_FRAME, 1, 25, dfst_pkg::FC_DEAUTH, 1, 2, 3, 4, 5, 6, 0);
		send_request(dfst_pkg::OP_FRAME, 1, 26, 8'hB0, 1, 2, 3, 4, 5, 6, 0);
		send_request(dfst_pkg::OP_FRAME, 1, 26, dfst_pkg::FC_DEAUTH, '1, '1, 8'hFF, 8'h80,
			4'hF, 32'hFFFF_FFF0, 0);
		send_request(dfst_pkg::OP_FRAME, 1, 12'hFFF, dfst_pkg::FC_DISASSOC, '0, '0, 0,
			8'h7F, 0, 10, 0);
		send_request(dfst_pkg::OP_FRAME, 1, 30, dfst_pkg::FC_DISASSOC, '1, '1, 1, 8'hFF,
			3, 20, 0);
		send_request(dfst_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1);
		send_request(dfst_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0, 2);
		send_request(dfst_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0, 8'hFF);
		send_request(2'd3, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_request(dfst_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1000, 0);
		send_request(dfst_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 999, 0); // time wrap
		drain();
		write_reg(dfst_pkg::CFG_UPDATE_INTERVAL, 16'd0);
		write_reg(dfst_pkg::CFG_ALERT_THRESHOLD, 16'd0);
		send_request(dfst_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 999, 0);
		for (int i = 0; i < 5; i++)
			frame(48'({$urandom, $urandom}), 48'd7, dfst_pkg::FC_DEAUTH);
		send_request(dfst_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1000, 0); // raises an alert
		drain();

		// random phases over several register settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(dfst_pkg::CFG_UPDATE_INTERVAL, 16'd1000);
					write_reg(dfst_pkg::CFG_ALERT_THRESHOLD, 16'd10); end
				1: begin write_reg(dfst_pkg::CFG_UPDATE_INTERVAL, 16'hFFFF);
					write_reg(dfst_pkg::CFG_ALERT_THRESHOLD, 16'hFFFF); end
				2: begin write_reg(dfst_pkg::CFG_UPDATE_INTERVAL, 16'd1);
					write_reg(dfst_pkg::CFG_ALERT_THRESHOLD, 16'd0); end
				default: begin
					write_reg(dfst_pkg::CFG_UPDATE_INTERVAL, 16'($urandom_range(1, 3000)));
					write_reg(dfst_pkg::CFG_ALERT_THRESHOLD, 16'($urandom_range(0, 200)));
				end
			endcase
			for (int n = 0; n < 250; n++) random_request();
			drain();
		end
		done = 1;
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
